// ===== hdl/bvod_pkg.sv =====
// ----------------------------------------------------------------------------
// Bass voice package
// Shared types, constants, the sine table builder and the control store of
// the microcoded sequencer.
// ----------------------------------------------------------------------------
package bvod_pkg;

  // Table size of the sine ROM; a power of two between 64 and 4096.
  localparam int unsigned DEF_TABLE_SIZE = 1024;

  // Sample and arithmetic widths.
  localparam int unsigned XW     = 16;  // raw and decayed samples
  localparam int unsigned SUMW   = 18;  // x + 2*x1 + x2
  localparam int unsigned YW     = 18;  // filter output, Q2.15
  localparam int unsigned COEFW  = 25;  // Q4.20 coefficients
  localparam int unsigned MULW   = 29;  // multiplier operands
  localparam int unsigned PRODW  = 2 * MULW;
  localparam int unsigned ACCW   = 46;  // biquad accumulator, Q.35
  localparam int unsigned CNTW   = 24;  // sample countdown
  localparam int unsigned DCNTW  = 13;  // countdown width below the decay span

  // Linear decay over the last samples of a note.
  localparam logic [CNTW-1:0] DECAY_SPAN = 24'd5000;
  // Reciprocal of the decay span, scaled by 2^40 and rounded up, so that
  // floor(m * DECAY_RECIP / 2^40) equals floor(m / 5000) for every product.
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [27:0] DECAY_RECIP =
    28'(((64'd1 << RECIP_SHIFT) + 64'd4999) / 64'd5000);

  // Sawtooth midpoint and output saturation bounds.
  localparam logic signed [XW-1:0]  SAW_HALF   = 16'sd16384;
  localparam logic signed [ACCW-21:0] SAMPLE_MAX = 26'sd131071;
  localparam logic signed [ACCW-21:0] SAMPLE_MIN = -26'sd131072;
  localparam logic signed [ACCW-1:0] ROUND_HALF = 46'sd524288;

  // Fixed-point angles for building the sine table, Q30.
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  // Request codes.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_NOTE   = 2'd1;
  localparam logic [1:0] REQ_LEN    = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 25;
  localparam logic [CFG_IW-1:0] REG_WAVEFORM = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COEF_A0  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COEF_B1  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_COEF_B2  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SPT      = 3'd4;

  // Beat payloads.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] phase_inc;
    logic [7:0]  length_ticks;
  } in_beat_t;

  typedef struct packed {
    logic signed [YW-1:0] sample_out;
    logic                 voice_active;
  } out_beat_t;

  // Configuration register file contents.
  typedef struct packed {
    logic                    waveform;
    logic signed [COEFW-1:0] coef_a0;
    logic signed [COEFW-1:0] coef_b1;
    logic signed [COEFW-1:0] coef_b2;
    logic [15:0]             samples_per_tick;
  } cfg_t;

  // Control word fields.
  typedef logic [3:0] step_t;

  typedef enum logic [1:0] {
    J_NEVER,
    J_COUNT_ZERO,
    J_NO_DECAY
  } jump_cond_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_LEN,
    MS_DECAY,
    MS_RECIP,
    MS_A0,
    MS_B1,
    MS_B2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_NOTE,
    OP_LEN_LOAD,
    OP_RAW,
    OP_DECAY,
    OP_COUNT_DEC,
    OP_FILT_OUT,
    OP_IDLE_OUT
  } dp_op_t;

  typedef struct packed {
    jump_cond_t jump;
    step_t      target;
    mul_sel_t   mul;
    acc_op_t    acc;
    dp_op_t     op;
    logic       last;
  } ucode_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic   exec;
    ucode_t word;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic count_zero;
    logic no_decay;
    logic out_full;
  } status_t;

  // Program addresses.
  localparam step_t ST_NOTE     = 4'd0;
  localparam step_t ST_LEN0     = 4'd1;
  localparam step_t ST_LEN1     = 4'd2;
  localparam step_t ST_TICK0    = 4'd3;
  localparam step_t ST_TICK1    = 4'd4;
  localparam step_t ST_TICK2    = 4'd5;
  localparam step_t ST_TICK3    = 4'd6;
  localparam step_t ST_TICK4    = 4'd7;
  localparam step_t ST_FILT0    = 4'd8;
  localparam step_t ST_FILT1    = 4'd9;
  localparam step_t ST_FILT2    = 4'd10;
  localparam step_t ST_FILT3    = 4'd11;
  localparam step_t ST_FILT4    = 4'd12;
  localparam step_t ST_IDLE_OUT = 4'd13;

  // Control store: one word per step.
  function automatic ucode_t ucode_word(input step_t step);
    ucode_t w;
    w = '{jump: J_NEVER, target: ST_NOTE, mul: MS_NONE, acc: ACC_HOLD,
          op: OP_NONE, last: 1'b1};
    case (step)
      ST_NOTE: begin
        w.op = OP_NOTE;
      end
      ST_LEN0: begin
        w.mul  = MS_LEN;
        w.last = 1'b0;
      end
      ST_LEN1: begin
        w.op = OP_LEN_LOAD;
      end
      ST_TICK0: begin
        w.jump   = J_COUNT_ZERO;
        w.target = ST_IDLE_OUT;
        w.last   = 1'b0;
      end
      ST_TICK1: begin
        w.op   = OP_RAW;
        w.last = 1'b0;
      end
      ST_TICK2: begin
        w.jump   = J_NO_DECAY;
        w.target = ST_FILT0;
        w.mul    = MS_DECAY;
        w.last   = 1'b0;
      end
      ST_TICK3: begin
        w.mul  = MS_RECIP;
        w.last = 1'b0;
      end
      ST_TICK4: begin
        w.op   = OP_DECAY;
        w.last = 1'b0;
      end
      ST_FILT0: begin
        w.op   = OP_COUNT_DEC;
        w.mul  = MS_A0;
        w.last = 1'b0;
      end
      ST_FILT1: begin
        w.acc  = ACC_LOAD;
        w.mul  = MS_B1;
        w.last = 1'b0;
      end
      ST_FILT2: begin
        w.acc  = ACC_ADD;
        w.mul  = MS_B2;
        w.last = 1'b0;
      end
      ST_FILT3: begin
        w.acc  = ACC_ADD;
        w.last = 1'b0;
      end
      ST_FILT4: begin
        w.op = OP_FILT_OUT;
      end
      ST_IDLE_OUT: begin
        w.op = OP_IDLE_OUT;
      end
      default: begin
        w.op = OP_NONE;
      end
    endcase
    return w;
  endfunction

  // Program entry for a request; an unknown code maps to the tick program.
  function automatic step_t entry_step(input logic [1:0] req);
    step_t s;
    case (req)
      REQ_NOTE: s = ST_NOTE;
      REQ_LEN:  s = ST_LEN0;
      default:  s = ST_TICK0;
    endcase
    return s;
  endfunction

  function automatic logic op_emits(input dp_op_t op);
    return (op == OP_FILT_OUT) || (op == OP_IDLE_OUT);
  endfunction

  // One sine table entry, half amplitude, built with a Q30 Taylor series.
  // Used only to build the constant table at elaboration.
  function automatic logic signed [XW-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned aw);
    logic [63:0]        theta;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prodt;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    logic               neg;
    theta = (TWO_PI_Q30 * 64'(k)) >> aw;
    neg   = 1'b0;
    if (theta >= PI_Q30) begin
      theta = theta - PI_Q30;
      neg   = 1'b1;
    end
    if (theta > HALF_PI_Q30) begin
      theta = PI_Q30 - theta;
    end
    x2   = (theta * theta) >> 30;
    term = theta;
    sum  = signed'(theta);
    for (int n = 1; n <= 7; n++) begin
      prodt = (term * x2) >> 30;
      case (n)
        1:       term = prodt / 64'd6;
        2:       term = prodt / 64'd20;
        3:       term = prodt / 64'd42;
        4:       term = prodt / 64'd72;
        5:       term = prodt / 64'd110;
        6:       term = prodt / 64'd156;
        default: term = prodt / 64'd210;
      endcase
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd32768) >>> 16;
    return neg ? XW'(-v) : XW'(v);
  endfunction

endpackage

// ===== hdl/bvod_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Bass voice sine ROM
// Half-amplitude sine table with a registered read port.
// ----------------------------------------------------------------------------
module bvod_sine_rom #(
  parameter int unsigned TABLE_SIZE = bvod_pkg::DEF_TABLE_SIZE
) (
  input  logic                              clk,
  input  logic [$clog2(TABLE_SIZE)-1:0]     addr,
  output logic signed [bvod_pkg::XW-1:0]    data
);
  import bvod_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  typedef logic signed [XW-1:0] rom_arr_t [TABLE_SIZE];

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      r[i] = sine_entry(i, AW);
    end
    return r;
  endfunction

  localparam rom_arr_t SINE_TABLE = build_rom();

  // Registered read.
  always_ff @(posedge clk) begin
    data <= SINE_TABLE[addr];
  end

endmodule

// ===== hdl/bvod_seq.sv =====
// ----------------------------------------------------------------------------
// Bass voice sequencer
// Step counter over the control store, with conditional jumps and a hold
// on the output step while the result register is still full.
// ----------------------------------------------------------------------------
module bvod_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        start_req,
  input  bvod_pkg::status_t status,
  output logic              busy,
  output bvod_pkg::ctrl_t   ctrl
);
  import bvod_pkg::*;

  step_t  step;
  step_t  step_next;
  logic   busy_next;
  ucode_t word;
  logic   stall;
  logic   jump_taken;

  // Decode the current control word and pick the next step.
  always_comb begin
    word  = ucode_word(step);
    stall = busy && word.last && op_emits(word.op) && status.out_full;
    case (word.jump)
      J_COUNT_ZERO: jump_taken = status.count_zero;
      J_NO_DECAY:   jump_taken = status.no_decay;
      default:      jump_taken = 1'b0;
    endcase

    step_next = step;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        step_next = entry_step(start_req);
      end
    end else if (!stall) begin
      if (word.last) begin
        busy_next = 1'b0;
      end else if (jump_taken) begin
        step_next = word.target;
      end else begin
        step_next = step + step_t'(1);
      end
    end

    ctrl.exec = busy && !stall;
    ctrl.word = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_NOTE;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

// ===== hdl/bvod_dp.sv =====
// ----------------------------------------------------------------------------
// Bass voice datapath
// Oscillator, countdown, shared multiplier, biquad accumulator and the
// result register, all steered by the sequencer's control word.
// ----------------------------------------------------------------------------
module bvod_dp #(
  parameter int unsigned TABLE_SIZE = bvod_pkg::DEF_TABLE_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  input  bvod_pkg::cfg_t      cfg,
  input  logic                load,
  input  bvod_pkg::in_beat_t  in_data,
  input  bvod_pkg::ctrl_t     ctrl,
  output bvod_pkg::status_t   status,
  output logic                out_valid,
  input  logic                out_ready,
  output bvod_pkg::out_beat_t out_data
);
  import bvod_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  // Architectural state.
  logic [31:0]           phase;
  logic [31:0]           phase_step;
  logic [CNTW-1:0]       remaining;
  logic signed [XW-1:0]  in_delay_one;
  logic signed [XW-1:0]  in_delay_two;
  logic signed [YW-1:0]  out_delay_one;
  logic signed [YW-1:0]  out_delay_two;

  // Working registers.
  in_beat_t               req;
  logic signed [XW-1:0]   xs;
  logic signed [PRODW-1:0] prod;
  logic signed [ACCW-1:0] acc;

  // Combinational values.
  logic signed [XW-1:0]   rom_q;
  logic signed [XW-1:0]   saw;
  logic signed [SUMW-1:0] tap_sum;
  logic signed [MULW-1:0] mul_a;
  logic signed [MULW-1:0] mul_b;
  logic signed [PRODW-1:0] prod_mag;
  logic [14:0]            quot;
  logic signed [ACCW-1:0] acc_round;
  logic signed [ACCW-21:0] y_wide;
  logic signed [YW-1:0]   y_sat;

  bvod_sine_rom #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_rom (
    .clk  (clk),
    .addr (phase[31 -: AW]),
    .data (rom_q)
  );

  // Sawtooth and the feedforward tap sum.
  always_comb begin
    saw     = SAW_HALF - signed'({1'b0, phase[31:17]});
    tap_sum = SUMW'(xs) + (SUMW'(in_delay_one) <<< 1) + SUMW'(in_delay_two);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    prod_mag = prod[PRODW-1] ? -prod : prod;
    case (ctrl.word.mul)
      MS_LEN: begin
        mul_a = MULW'({1'b0, req.length_ticks});
        mul_b = MULW'({1'b0, cfg.samples_per_tick});
      end
      MS_DECAY: begin
        mul_a = MULW'(xs);
        mul_b = MULW'({1'b0, remaining[DCNTW-1:0]});
      end
      MS_RECIP: begin
        mul_a = MULW'({1'b0, prod_mag[26:0]});
        mul_b = MULW'({1'b0, DECAY_RECIP});
      end
      MS_A0: begin
        mul_a = MULW'(cfg.coef_a0);
        mul_b = MULW'(tap_sum);
      end
      MS_B1: begin
        mul_a = MULW'(cfg.coef_b1);
        mul_b = MULW'(out_delay_one);
      end
      MS_B2: begin
        mul_a = MULW'(cfg.coef_b2);
        mul_b = MULW'(out_delay_two);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Decay quotient, rounding and saturation of the filter output.
  always_comb begin
    quot      = prod[RECIP_SHIFT +: 15];
    acc_round = acc + ROUND_HALF;
    y_wide    = acc_round[ACCW-1:20];
    if (y_wide > SAMPLE_MAX) begin
      y_sat = YW'(SAMPLE_MAX);
    end else if (y_wide < SAMPLE_MIN) begin
      y_sat = YW'(SAMPLE_MIN);
    end else begin
      y_sat = YW'(y_wide);
    end
  end

  always_comb begin
    status.count_zero = (remaining == '0);
    status.no_decay   = (remaining >= DECAY_SPAN);
    status.out_full   = out_valid && !out_ready;
  end

  // Multiplier with its output register.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    if (load) begin
      req <= in_data;
    end
    if (ctrl.exec) begin
      case (ctrl.word.acc)
        ACC_LOAD: acc <= prod[ACCW-1:0];
        ACC_ADD:  acc <= acc + prod[ACCW-1:0];
        default:  acc <= acc;
      endcase
      case (ctrl.word.op)
        OP_RAW:   xs <= cfg.waveform ? rom_q : saw;
        OP_DECAY: xs <= xs[XW-1] ? -XW'({1'b0, quot}) : XW'({1'b0, quot});
        default:  xs <= xs;
      endcase
    end
  end

  // Voice state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      phase_step    <= '0;
      remaining     <= '0;
      in_delay_one  <= '0;
      in_delay_two  <= '0;
      out_delay_one <= '0;
      out_delay_two <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A new result takes priority over the departing one.
      if (ctrl.exec && op_emits(ctrl.word.op)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.exec) begin
        case (ctrl.word.op)
          OP_NOTE: begin
            phase_step <= req.phase_inc;
            phase      <= '0;
            remaining  <= CNTW'(cfg.samples_per_tick);
          end
          OP_LEN_LOAD: begin
            remaining <= prod[CNTW-1:0];
          end
          OP_RAW: begin
            phase <= phase + phase_step;
          end
          OP_COUNT_DEC: begin
            remaining <= remaining - CNTW'(1);
          end
          OP_FILT_OUT: begin
            in_delay_two          <= in_delay_one;
            in_delay_one          <= xs;
            out_delay_two         <= out_delay_one;
            out_delay_one         <= y_sat;
            out_data.sample_out   <= y_sat;
            out_data.voice_active <= 1'b1;
          end
          OP_IDLE_OUT: begin
            out_data.sample_out   <= '0;
            out_data.voice_active <= 1'b0;
          end
          default: begin
            phase <= phase;
          end
        endcase
      end
    end
  end

endmodule

// ===== hdl/bass_voice_osc_decay_biquad_top.sv =====
// ----------------------------------------------------------------------------
// Bass voice top level
// Phase-accumulator oscillator with linear decay and a biquad lowpass,
// run by a microcoded sequencer over one shared multiplier.
//
//   Channel  Signals                      Carries
//   in       in_valid/in_ready, in_data   request: tick, note on, set length
//   out      out_valid/out_ready, out_data  filtered sample and active flag
//   cfg      cfg_we, cfg_index, cfg_data  register writes, no read-back
//
// A sample tick skips the decay steps above the decay span and the filter
// steps when the voice is silent; a note on and a set length run short
// programs of their own. No new beat is taken until the program ends, as the
// sequencer passes every product through the one multiplier.
// Reset is synchronous; it clears the voice and the filter and sets the
// configuration registers to their defaults. The result register lets the
// next beat in while a result waits; the sequencer holds on its output step only if that register is still full.
// ----------------------------------------------------------------------------
module bass_voice_osc_decay_biquad_top #(
  parameter int unsigned TABLE_SIZE = bvod_pkg::DEF_TABLE_SIZE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bvod_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bvod_pkg::out_beat_t              out_data,
  input  logic                             cfg_we,
  input  logic [bvod_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [bvod_pkg::CFG_DW-1:0]      cfg_data
);
  import bvod_pkg::*;

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;
  logic    busy;
  logic    accept;
  logic    start;

  // A beat is taken whenever the sequencer is free and out of reset; an
  // unknown request code starts nothing.
  always_comb begin
    in_ready = !busy && !rst;
    accept   = in_valid && in_ready;
    start    = accept && (in_data.req_type inside {REQ_TICK, REQ_NOTE, REQ_LEN});
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform         <= 1'b0;
      cfg.coef_a0          <= 25'sd37802;
      cfg.coef_b1          <= 25'sd1611100;
      cfg.coef_b2          <= -25'sd713770;
      cfg.samples_per_tick <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVEFORM: cfg.waveform         <= cfg_data[0];
        REG_COEF_A0:  cfg.coef_a0          <= cfg_data;
        REG_COEF_B1:  cfg.coef_b1          <= cfg_data;
        REG_COEF_B2:  cfg.coef_b2          <= cfg_data;
        REG_SPT:      cfg.samples_per_tick <= cfg_data[15:0];
        default:      cfg.waveform         <= cfg.waveform;
      endcase
    end
  end

  bvod_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_req (in_data.req_type),
    .status    (status),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  bvod_dp #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .load      (accept),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
